// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the checker files of the RTF escaper.
// Every macro takes a label, a clock, an active-low reset and two expressions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is held.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, off while reset is held.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/core/rte_pkg.sv -----
// Package of the RTF escaper: character codes, reciprocal constants and
// the word types passed between pipeline stages. No dependencies.
`timescale 1ns / 1ps

package rte_pkg;

    localparam int unsigned MAX_RUN    = 9;
    localparam int unsigned NUM_DIGITS = 5;

    typedef logic [6:0] t_byte;

    // Input code units that need special handling
    localparam logic [15:0] CU_BSLASH   = 16'h005C;
    localparam logic [15:0] CU_LBRACE   = 16'h007B;
    localparam logic [15:0] CU_RBRACE   = 16'h007D;
    localparam logic [15:0] CU_TAB      = 16'h0009;
    localparam logic [15:0] CU_PRINT_LO = 16'h0020;
    localparam logic [15:0] CU_UNI_LO   = 16'h0080;
    localparam logic [15:0] CU_NEG_LO   = 16'h8000;

    // Output characters
    localparam t_byte CH_NUL    = 7'h00;
    localparam t_byte CH_BSLASH = 7'h5C;
    localparam t_byte CH_T      = 7'h74;
    localparam t_byte CH_A      = 7'h61;
    localparam t_byte CH_B      = 7'h62;
    localparam t_byte CH_SPACE  = 7'h20;
    localparam t_byte CH_U      = 7'h75;
    localparam t_byte CH_MINUS  = 7'h2D;
    localparam t_byte CH_QMARK  = 7'h3F;
    localparam t_byte CH_ZERO   = 7'h30;

    // Reciprocals for division by constants, each followed by a shift
    localparam logic [14:0] RECIP_1000 = 15'd16777;  // >> 24, may be low by one
    localparam logic [7:0]  RECIP_10   = 8'd205;     // >> 11, exact below 1029
    localparam logic [5:0]  RECIP_100  = 6'd41;      // >> 12, exact below 1000
    localparam logic [9:0]  K_THOUSAND = 10'd1000;
    localparam logic [6:0]  K_HUNDRED  = 7'd100;
    localparam logic [3:0]  K_TEN      = 4'd10;

    typedef enum logic [2:0] {
        CLS_DROP  = 3'd0,
        CLS_ESC   = 3'd1,
        CLS_TAB   = 3'd2,
        CLS_PLAIN = 3'd3,
        CLS_UNI   = 3'd4
    } t_class;

    // Classified code unit
    typedef struct packed {
        t_class      cls;
        t_byte       chr;
        logic        neg;
        logic [15:0] mag;
        logic        eot;
    } t_cls_word;

    // Code unit with the decimal digits of its magnitude, last two still joined
    typedef struct packed {
        t_class     cls;
        t_byte      chr;
        logic       neg;
        logic [3:0] d4;
        logic [3:0] d3;
        logic [3:0] d2;
        logic [6:0] lo2;
        logic       eot;
    } t_dig_word;

    // Complete byte run of one code unit, first byte in slot 0
    typedef struct packed {
        logic [MAX_RUN-1:0][6:0] bytes;
        logic [3:0]              cnt;
        logic                    bvalid;
        logic                    eot;
    } t_run;

endpackage

// ----- rtl/core/rte_classify.sv -----
// First pipeline stage: sorts each code unit into its escape class and
// forms the magnitude of its signed 16-bit value. Uses rte_pkg.
`timescale 1ns / 1ps

module rte_classify (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [15:0]        i_code_unit,
    input  logic               i_end_of_text,
    output logic               o_valid,
    input  logic               i_ready,
    output rte_pkg::t_cls_word o_data
);

    rte_pkg::t_cls_word n_data;
    rte_pkg::t_cls_word r_data;
    logic               r_valid;

    always_comb begin
        n_data     = '0;
        n_data.chr = i_code_unit[6:0];
        n_data.eot = i_end_of_text;
        n_data.mag = i_code_unit;
        n_data.neg = 1'b0;
        if (i_code_unit == rte_pkg::CU_BSLASH || i_code_unit == rte_pkg::CU_LBRACE
                || i_code_unit == rte_pkg::CU_RBRACE) begin
            n_data.cls = rte_pkg::CLS_ESC;
        end else if (i_code_unit == rte_pkg::CU_TAB) begin
            n_data.cls = rte_pkg::CLS_TAB;
        end else if (i_code_unit >= rte_pkg::CU_PRINT_LO
                && i_code_unit < rte_pkg::CU_UNI_LO) begin
            n_data.cls = rte_pkg::CLS_PLAIN;
        end else if (i_code_unit >= rte_pkg::CU_UNI_LO) begin
            n_data.cls = rte_pkg::CLS_UNI;
            if (i_code_unit >= rte_pkg::CU_NEG_LO) begin
                // two's complement magnitude, 0x8000 stays 32768
                n_data.neg = 1'b1;
                n_data.mag = 16'(17'h10000 - {1'b0, i_code_unit});
            end
        end else begin
            n_data.cls = rte_pkg::CLS_DROP;
        end
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

// ----- rtl/core/rte_digits.sv -----
// Three pipeline stages that take the magnitude apart into decimal digits
// by reciprocal multiplication: thousands split, correction, digit split.
// Uses rte_pkg.
`timescale 1ns / 1ps

module rte_digits (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  rte_pkg::t_cls_word i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output rte_pkg::t_dig_word o_data
);

    typedef struct packed {
        rte_pkg::t_class cls;
        rte_pkg::t_byte  chr;
        logic            neg;
        logic [15:0]     mag;
        logic [5:0]      q0;
        logic            eot;
    } t_quo_word;

    typedef struct packed {
        rte_pkg::t_class cls;
        rte_pkg::t_byte  chr;
        logic            neg;
        logic [5:0]      hi;
        logic [9:0]      lo;
        logic            eot;
    } t_split_word;

    logic               r_v1;
    logic               r_v2;
    logic               r_v3;
    t_quo_word          r_quo;
    t_split_word        r_split;
    rte_pkg::t_dig_word r_dig;

    t_quo_word          n_quo;
    t_split_word        n_split;
    rte_pkg::t_dig_word n_dig;

    logic        v_adv1;
    logic        v_adv2;
    logic        v_adv3;
    logic [30:0] v_prod_q;
    logic [15:0] v_rem_full;
    logic [10:0] v_rem;
    logic [12:0] v_prod_hi;
    logic [15:0] v_prod_lo;

    assign v_adv3  = !r_v3 || i_ready;
    assign v_adv2  = !r_v2 || v_adv3;
    assign v_adv1  = !r_v1 || v_adv2;
    assign o_ready = v_adv1;
    assign o_valid = r_v3;
    assign o_data  = r_dig;

    // Estimate magnitude / 1000
    always_comb begin
        v_prod_q  = 31'(i_data.mag) * 31'(rte_pkg::RECIP_1000);
        n_quo.cls = i_data.cls;
        n_quo.chr = i_data.chr;
        n_quo.neg = i_data.neg;
        n_quo.mag = i_data.mag;
        n_quo.q0  = v_prod_q[29:24];
        n_quo.eot = i_data.eot;
    end

    // Fix the estimate: the remainder may still hold one more thousand
    always_comb begin
        v_rem_full  = r_quo.mag - 16'(r_quo.q0) * 16'(rte_pkg::K_THOUSAND);
        v_rem       = v_rem_full[10:0];
        n_split.cls = r_quo.cls;
        n_split.chr = r_quo.chr;
        n_split.neg = r_quo.neg;
        n_split.eot = r_quo.eot;
        if (v_rem >= 11'(rte_pkg::K_THOUSAND)) begin
            n_split.hi = r_quo.q0 + 6'd1;
            n_split.lo = 10'(v_rem - 11'(rte_pkg::K_THOUSAND));
        end else begin
            n_split.hi = r_quo.q0;
            n_split.lo = v_rem[9:0];
        end
    end

    // Split thousands into two digits and peel the hundreds digit
    always_comb begin
        v_prod_hi = 13'(r_split.hi) * 13'(rte_pkg::RECIP_10);
        v_prod_lo = 16'(r_split.lo) * 16'(rte_pkg::RECIP_100);
        n_dig.cls = r_split.cls;
        n_dig.chr = r_split.chr;
        n_dig.neg = r_split.neg;
        n_dig.eot = r_split.eot;
        n_dig.d4  = 4'(v_prod_hi >> 11);
        n_dig.d3  = 4'(r_split.hi - 6'(n_dig.d4) * 6'(rte_pkg::K_TEN));
        n_dig.d2  = v_prod_lo[15:12];
        n_dig.lo2 = 7'(r_split.lo - 10'(n_dig.d2) * 10'(rte_pkg::K_HUNDRED));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (v_adv1) begin
                r_v1 <= i_valid;
            end
            if (v_adv2) begin
                r_v2 <= r_v1;
            end
            if (v_adv3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (v_adv1 && i_valid) begin
            r_quo <= n_quo;
        end
        if (v_adv2 && r_v1) begin
            r_split <= n_split;
        end
        if (v_adv3 && r_v2) begin
            r_dig <= n_dig;
        end
    end

endmodule

// ----- rtl/core/rte_assemble.sv -----
// Pipeline stage that finishes the last two digits and lays out the
// complete byte run of one code unit with its length. Uses rte_pkg.
`timescale 1ns / 1ps

module rte_assemble (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  rte_pkg::t_dig_word i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output rte_pkg::t_run      o_data
);

    logic          r_valid;
    rte_pkg::t_run r_run;
    rte_pkg::t_run n_run;

    logic [14:0] v_prod;
    logic [3:0]  v_d1;
    logic [3:0]  v_d0;
    logic [3:0]  v_dig [rte_pkg::NUM_DIGITS];
    logic [3:0]  v_lead;
    logic [3:0]  v_pos;

    always_comb begin
        v_prod = 15'(i_data.lo2) * 15'(rte_pkg::RECIP_10);
        v_d1   = v_prod[14:11];
        v_d0   = 4'(i_data.lo2 - 7'(v_d1) * 7'(rte_pkg::K_TEN));
        v_dig[0] = i_data.d4;
        v_dig[1] = i_data.d3;
        v_dig[2] = i_data.d2;
        v_dig[3] = v_d1;
        v_dig[4] = v_d0;
        // first nonzero digit; the least significant always stays
        v_lead = 4'(rte_pkg::NUM_DIGITS - 1);
        for (int j = rte_pkg::NUM_DIGITS - 1; j >= 0; j--) begin
            if (v_dig[j] != 4'd0) begin
                v_lead = 4'(j);
            end
        end
        v_pos = i_data.neg ? 4'd3 : 4'd2;
    end

    always_comb begin
        n_run        = '0;
        n_run.eot    = i_data.eot;
        n_run.bvalid = 1'b1;
        case (i_data.cls)
            rte_pkg::CLS_ESC: begin
                n_run.bytes[0] = rte_pkg::CH_BSLASH;
                n_run.bytes[1] = i_data.chr;
                n_run.cnt      = 4'd2;
            end
            rte_pkg::CLS_TAB: begin
                n_run.bytes[0] = rte_pkg::CH_BSLASH;
                n_run.bytes[1] = rte_pkg::CH_T;
                n_run.bytes[2] = rte_pkg::CH_A;
                n_run.bytes[3] = rte_pkg::CH_B;
                n_run.bytes[4] = rte_pkg::CH_SPACE;
                n_run.cnt      = 4'd5;
            end
            rte_pkg::CLS_PLAIN: begin
                n_run.bytes[0] = i_data.chr;
                n_run.cnt      = 4'd1;
            end
            rte_pkg::CLS_UNI: begin
                n_run.bytes[0] = rte_pkg::CH_BSLASH;
                n_run.bytes[1] = rte_pkg::CH_U;
                n_run.bytes[2] = rte_pkg::CH_MINUS;
                for (int j = 0; j < rte_pkg::NUM_DIGITS; j++) begin
                    if (4'(j) >= v_lead) begin
                        n_run.bytes[v_pos + 4'(j) - v_lead] =
                            rte_pkg::CH_ZERO + 7'(v_dig[j]);
                    end
                end
                n_run.bytes[v_pos + 4'(rte_pkg::NUM_DIGITS) - v_lead] = rte_pkg::CH_QMARK;
                n_run.cnt = v_pos + 4'(rte_pkg::NUM_DIGITS) - v_lead + 4'd1;
            end
            default: begin
                // dropped control code: one empty word
                n_run.bvalid = 1'b0;
                n_run.cnt    = 4'd1;
            end
        endcase
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_run;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_run <= n_run;
        end
    end

endmodule

// ----- rtl/core/rte_serializer.sv -----
// Output stage: holds one byte run and hands it out one word per
// handshake, shifting the run down as words leave. Uses rte_pkg.
`timescale 1ns / 1ps

module rte_serializer (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  rte_pkg::t_run  i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output rte_pkg::t_byte o_out_byte,
    output logic           o_byte_valid,
    output logic           o_last_of_run,
    output logic           o_text_done
);

    logic                                    r_valid;
    logic [rte_pkg::MAX_RUN-1:0][6:0]        r_bytes;
    logic [3:0]                              r_cnt;
    logic                                    r_bvalid;
    logic                                    r_eot;

    logic v_last;
    logic v_take;

    assign v_last  = (r_cnt == 4'd1);
    assign v_take  = r_valid && i_ready;
    // Load the next run as the last word of this one leaves
    assign o_ready = !r_valid || (i_ready && v_last);

    assign o_valid       = r_valid;
    assign o_out_byte    = r_bytes[0];
    assign o_byte_valid  = r_bvalid;
    assign o_last_of_run = v_last;
    assign o_text_done   = r_eot && v_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_bytes  <= i_data.bytes;
            r_cnt    <= i_data.cnt;
            r_bvalid <= i_data.bvalid;
            r_eot    <= i_data.eot;
        end else if (v_take && !v_last) begin
            // advance to the next byte of the run
            r_bytes <= {rte_pkg::CH_NUL, r_bytes[rte_pkg::MAX_RUN-1:1]};
            r_cnt   <= r_cnt - 4'd1;
        end
    end

endmodule

// ----- rtl/core/rtf_text_escaper.sv -----
// A code unit accepted at a clock edge passes six register stages (classify, three
// digit stages, assemble, serializer) on its way to o_valid as its first word.
// Throughput: one code unit per cycle while each yields one word and i_ready is high;
// otherwise one word per cycle while i_ready is high, a unit holding the byte-wide
// output stage until the last of its 1 to 9 words leaves. Reset (synchronous, active
// low) clears all stage valid bits; the pipeline is empty and ready on the next cycle.
`timescale 1ns / 1ps

module rtf_text_escaper (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [15:0] i_code_unit,
    input  logic        i_end_of_text,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [6:0]  o_out_byte,
    output logic        o_byte_valid,
    output logic        o_last_of_run,
    output logic        o_text_done
);

    logic               cls_valid;
    logic               cls_ready;
    rte_pkg::t_cls_word cls_data;
    logic               dig_valid;
    logic               dig_ready;
    rte_pkg::t_dig_word dig_data;
    logic               run_valid;
    logic               run_ready;
    rte_pkg::t_run      run_data;

    rte_classify u_classify (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_code_unit   (i_code_unit),
        .i_end_of_text (i_end_of_text),
        .o_valid       (cls_valid),
        .i_ready       (cls_ready),
        .o_data        (cls_data)
    );

    rte_digits u_digits (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (cls_valid),
        .o_ready (cls_ready),
        .i_data  (cls_data),
        .o_valid (dig_valid),
        .i_ready (dig_ready),
        .o_data  (dig_data)
    );

    rte_assemble u_assemble (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (dig_valid),
        .o_ready (dig_ready),
        .i_data  (dig_data),
        .o_valid (run_valid),
        .i_ready (run_ready),
        .o_data  (run_data)
    );

    rte_serializer u_serializer (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (run_valid),
        .o_ready       (run_ready),
        .i_data        (run_data),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_out_byte    (o_out_byte),
        .o_byte_valid  (o_byte_valid),
        .o_last_of_run (o_last_of_run),
        .o_text_done   (o_text_done)
    );

endmodule

// ----- rtl/core/rte_checker.sv -----
// Port-level checker for the RTF escaper and its bind to the top level.
// Depends on assert_macros.svh and rte_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rte_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [6:0] i_out_byte,
    input logic       i_byte_valid,
    input logic       i_last_of_run,
    input logic       i_text_done
);

    // A stalled word holds
    `ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_byte) && $stable(i_last_of_run))

    // End of text only on the closing word of a run
    `ASSERT_IMPLY(a_done_on_last, i_clk, i_rst_n, i_out_valid && i_text_done, i_last_of_run)

    // A dropped unit is a single empty word
    `ASSERT_IMPLY(a_drop_single, i_clk, i_rst_n, i_out_valid && !i_byte_valid, i_last_of_run && (i_out_byte == rte_pkg::CH_NUL))

    // Escaped text never carries a byte below the space character
    `ASSERT_IMPLY(a_printable, i_clk, i_rst_n, i_out_valid && i_byte_valid, i_out_byte >= rte_pkg::CH_SPACE)

endmodule

bind rtf_text_escaper rte_checker u_rte_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_valid),
    .i_out_ready   (i_ready),
    .i_out_byte    (o_out_byte),
    .i_byte_valid  (o_byte_valid),
    .i_last_of_run (o_last_of_run),
    .i_text_done   (o_text_done)
);

// ----- bench/testbench.sv -----
// Self-checking bench for rtf_text_escaper: directed table plus random code units,
// random idling on both sides and one long output stall. Depends on rte_pkg.
`timescale 1ns / 1ps

module testbench;

    typedef struct packed {
        rte_pkg::t_byte chr;
        logic           bvalid;
        logic           last;
        logic           done;
    } t_rtf_word;

    localparam int NUM_RANDOM = 136;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [15:0] i_code_unit;
    logic        i_end_of_text;
    logic        o_valid;
    logic        i_ready;
    logic [6:0]  o_out_byte;
    logic        o_byte_valid;
    logic        o_last_of_run;
    logic        o_text_done;

    t_rtf_word   escaped_words[$];
    int          mismatch_count = 0;
    int          units_sent     = 0;
    int          words_taken    = 0;
    logic        hold_off       = 1'b0;

    // directed table
    logic [15:0] row_cu[$];
    logic        row_eot[$];
    bit          row_typed[$];
    string       row_txt[$];

    rtf_text_escaper i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_code_unit   (i_code_unit),
        .i_end_of_text (i_end_of_text),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_out_byte    (o_out_byte),
        .o_byte_valid  (o_byte_valid),
        .o_last_of_run (o_last_of_run),
        .o_text_done   (o_text_done)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    task automatic flag_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        mismatch_count++;
    endtask

    // Queue a run of bytes; an empty run becomes the single dropped-unit word.
    task automatic queue_run(input rte_pkg::t_byte run[$], input logic eot);
        t_rtf_word w;
        if (run.size() == 0) begin
            w = '{chr: rte_pkg::CH_NUL, bvalid: 1'b0, last: 1'b1, done: eot};
            escaped_words.push_back(w);
        end else begin
            for (int i = 0; i < run.size(); i++) begin
                w.chr    = run[i];
                w.bvalid = 1'b1;
                w.last   = (i == run.size() - 1);
                w.done   = (i == run.size() - 1) ? eot : 1'b0;
                escaped_words.push_back(w);
            end
        end
    endtask

    task automatic queue_typed_text(input string txt, input logic eot);
        rte_pkg::t_byte run[$];
        for (int i = 0; i < txt.len(); i++)
            run.push_back(rte_pkg::t_byte'(txt[i]));
        queue_run(run, eot);
    endtask

    task automatic escape_code_unit(input logic [15:0] cu, input logic eot);
        rte_pkg::t_byte run[$];
        rte_pkg::t_byte digs[$];
        logic [16:0]    mag;
        if (cu == rte_pkg::CU_BSLASH || cu == rte_pkg::CU_LBRACE
                || cu == rte_pkg::CU_RBRACE) begin
            run.push_back(rte_pkg::CH_BSLASH);
            run.push_back(cu[6:0]);
        end else if (cu == rte_pkg::CU_TAB) begin
            run.push_back(rte_pkg::CH_BSLASH);
            run.push_back(rte_pkg::CH_T);
            run.push_back(rte_pkg::CH_A);
            run.push_back(rte_pkg::CH_B);
            run.push_back(rte_pkg::CH_SPACE);
        end else if (cu >= rte_pkg::CU_PRINT_LO && cu < rte_pkg::CU_UNI_LO) begin
            run.push_back(cu[6:0]);
        end else if (cu >= rte_pkg::CU_UNI_LO) begin
            run.push_back(rte_pkg::CH_BSLASH);
            run.push_back(rte_pkg::CH_U);
            if (cu >= rte_pkg::CU_NEG_LO) begin
                run.push_back(rte_pkg::CH_MINUS);
                mag = 17'h10000 - {1'b0, cu};
            end else begin
                mag = {1'b0, cu};
            end
            do begin
                digs.push_front(rte_pkg::CH_ZERO + 7'(mag % 17'd10));
                mag = mag / 17'd10;
            end while (mag != 0);
            foreach (digs[i])
                run.push_back(digs[i]);
            run.push_back(rte_pkg::CH_QMARK);
        end
        queue_run(run, eot);
    endtask

    task automatic add_row(input logic [15:0] cu, input logic eot, input bit typed,
                           input string txt);
        row_cu.push_back(cu);
        row_eot.push_back(eot);
        row_typed.push_back(typed);
        row_txt.push_back(txt);
    endtask

    // Stretches of back-to-back traffic between stretches of random gaps.
    function automatic int draw_gap(input int count);
        if ((count % 40) < 12)
            return 0;
        return $urandom_range(0, 5);
    endfunction

    task automatic send_unit(input logic [15:0] cu, input logic eot, input bit typed,
                             input string txt);
        int gap;
        gap = draw_gap(units_sent);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_code_unit   <= cu;
        i_end_of_text <= eot;
        do @(posedge i_clk); while (!o_ready);
        if (typed)
            queue_typed_text(txt, eot);
        else
            escape_code_unit(cu, eot);
        units_sent++;
    endtask

    function automatic logic [15:0] pick_code_unit();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 30)
            return 16'($urandom_range(32'h20, 32'h7F));
        if (sel < 42) begin
            case ($urandom_range(0, 3))
                0:       return rte_pkg::CU_BSLASH;
                1:       return rte_pkg::CU_LBRACE;
                2:       return rte_pkg::CU_RBRACE;
                default: return rte_pkg::CU_TAB;
            endcase
        end
        if (sel < 52)
            return 16'($urandom_range(0, 32'h1F));
        if (sel < 78)
            return 16'($urandom);
        if (sel < 88)
            return 16'($urandom_range(32'h80, 32'h3FF));
        case ($urandom_range(0, 7))
            0:       return 16'd999;
            1:       return 16'd1000;
            2:       return 16'd9999;
            3:       return 16'd10000;
            4:       return 16'h7FFF;
            5:       return 16'h8000;
            6:       return 16'hFFFE;
            default: return 16'h8001;
        endcase
    endfunction

    task automatic check_word();
        t_rtf_word want;
        if (escaped_words.size() == 0) begin
            flag_mismatch($sformatf("unexpected word, byte %h", o_out_byte));
        end else begin
            want = escaped_words.pop_front();
            if (o_out_byte !== want.chr)
                flag_mismatch($sformatf("out_byte %h, want %h", o_out_byte, want.chr));
            if (o_byte_valid !== want.bvalid)
                flag_mismatch($sformatf("byte_valid %b, want %b", o_byte_valid, want.bvalid));
            if (o_last_of_run !== want.last)
                flag_mismatch($sformatf("last_of_run %b, want %b", o_last_of_run, want.last));
            if (o_text_done !== want.done)
                flag_mismatch($sformatf("text_done %b, want %b", o_text_done, want.done));
        end
    endtask

    // Output side: random stalls, plus the long hold-off when asked.
    initial begin
        int gap;
        i_ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            gap = draw_gap(words_taken);
            if (gap > 0 || hold_off) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
                while (hold_off) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            check_word();
            words_taken++;
        end
    end

    // Hold the output long enough that the pipeline fills and blocks the input.
    initial begin
        while (units_sent < 60) @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (120) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    initial begin
        #2_000_000;
        $display("[rtf_text_escaper] ERROR");
        $finish;
    end

    initial begin
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_code_unit   <= '0;
        i_end_of_text <= 1'b0;

        add_row(16'h0000, 1'b0, 1'b1, "");
        add_row(rte_pkg::CU_TAB, 1'b0, 1'b1, "\\tab ");
        add_row(16'h000A, 1'b0, 1'b1, "");
        add_row(16'h000D, 1'b0, 1'b1, "");
        add_row(16'h001F, 1'b1, 1'b1, "");
        add_row(16'h0020, 1'b0, 1'b1, " ");
        add_row(rte_pkg::CU_BSLASH, 1'b0, 1'b1, "\\\\");
        add_row(rte_pkg::CU_LBRACE, 1'b0, 1'b1, "\\{");
        add_row(rte_pkg::CU_RBRACE, 1'b0, 1'b1, "\\}");
        add_row(16'h0041, 1'b0, 1'b0, "");
        add_row(16'h007E, 1'b0, 1'b0, "");
        add_row(16'h007F, 1'b0, 1'b0, "");
        add_row(16'h0080, 1'b0, 1'b1, "\\u128?");
        add_row(16'h00FF, 1'b0, 1'b0, "");
        add_row(16'h03E8, 1'b0, 1'b0, "");
        add_row(16'h2710, 1'b0, 1'b0, "");
        add_row(16'h7FFF, 1'b0, 1'b1, "\\u32767?");
        add_row(16'h8000, 1'b0, 1'b1, "\\u-32768?");
        add_row(16'h8001, 1'b0, 1'b0, "");
        add_row(16'hFFFF, 1'b0, 1'b1, "\\u-1?");
        add_row(16'hD83D, 1'b0, 1'b0, "");
        add_row(rte_pkg::CU_BSLASH, 1'b1, 1'b1, "\\\\");
        add_row(rte_pkg::CU_TAB, 1'b1, 1'b0, "");
        add_row(16'h8000, 1'b1, 1'b0, "");

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (row_cu[i])
            send_unit(row_cu[i], row_eot[i], row_typed[i], row_txt[i]);
        for (int n = 0; n < NUM_RANDOM; n++)
            send_unit(pick_code_unit(), ($urandom_range(0, 7) == 0), 1'b0, "");
        i_valid <= 1'b0;

        // drain, then leave room for any stray word
        while (escaped_words.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("[rtf_text_escaper] OK");
        else
            $display("[rtf_text_escaper] ERROR");
        $finish;
    end

endmodule
